// ===== hw/rtl/tpdq_pkg.sv =====
// Package for the TPDF dither quantizer: widths, LCG constants, clamp limits and the queue word.
// No dependencies. Every other file of the block imports it.
package tpdq_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int OUT_W    = 24;
    localparam int SEED_W   = 32;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Linear congruential noise source
    localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD    = 32'd12345;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'h1EA7_F00D;

    // Width of the quantizer result before clamping: 66-bit sum shifted right by 33
    localparam int SUM_W   = 66;
    localparam int Q_SHIFT = 33;
    localparam int Q_W     = SUM_W - Q_SHIFT;

    // Clamp limits at the quotient width
    localparam logic signed [Q_W-1:0] LIM24_LO = -33'sd8388608;
    localparam logic signed [Q_W-1:0] LIM24_HI = 33'sd8388607;
    localparam logic signed [Q_W-1:0] LIM16_LO = -33'sd32768;
    localparam logic signed [Q_W-1:0] LIM16_HI = 33'sd32767;

    // Width mode codes
    localparam logic MODE_16 = 1'b0;
    localparam logic MODE_24 = 1'b1;

    // One queued word: the sample tagged with the width mode it was accepted under
    typedef struct packed {
        logic                       wide;
        logic signed [SAMPLE_W-1:0] sample;
    } qword_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== hw/rtl/tpdq_if.sv =====
// Stream interfaces for the TPDF dither quantizer: input samples and quantized results.
// Depends on tpdq_pkg for the field widths.
interface tpdq_in_if;
    import tpdq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface tpdq_out_if;
    import tpdq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/tpdq_front.sv =====
// Front of the quantizer: holds the width mode register, accepts sample words
// and tags each with its mode before pushing it into the queue. Uses tpdq_pkg, tpdq_in_if.
module tpdq_front
(
    input  logic              clk,
    input  logic              rst_n,
    tpdq_in_if.sink           din,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  tpdq_pkg::qstat_t  q_stat,
    output logic              push,
    output tpdq_pkg::qword_t  push_word
);
    import tpdq_pkg::*;

    logic mode_reg;
    logic mode_next;

    // Update the width mode on a write
    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_we)
        begin
            mode_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_16;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Accept a word whenever the queue has room
    assign din.ready = !q_stat.full;
    assign push      = din.valid && !q_stat.full;

    // Tag the word with the scaling it needs
    assign push_word.wide   = (mode_reg == MODE_24);
    assign push_word.sample = din.sample_in;

endmodule

// ===== hw/rtl/tpdq_queue.sv =====
// Short queue between the front and the back of the quantizer.
// Uses tpdq_pkg for the queue word and status types.
module tpdq_queue
#(
    parameter int DEPTH = tpdq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tpdq_pkg::qword_t  push_word,
    input  logic              pop,
    output tpdq_pkg::qword_t  head_word,
    output tpdq_pkg::qstat_t  q_stat
);
    import tpdq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qword_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word    = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== hw/rtl/tpdq_back.sv =====
// Back of the quantizer: steps the LCG twice through one shared multiplier, adds
// the dither to the scaled sample, floors, clamps and holds the result. Uses tpdq_pkg, tpdq_out_if.
module tpdq_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  tpdq_pkg::qstat_t  q_stat,
    input  tpdq_pkg::qword_t  head_word,
    output logic              pop,
    tpdq_out_if.source        dout
);
    import tpdq_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STEP2  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [SEED_W-1:0]          seed_reg;
    logic [SEED_W-1:0]          seed_next;
    logic [SEED_W-1:0]          d1_reg;
    logic [SEED_W-1:0]          d1_next;
    logic [SEED_W:0]            dsum_reg;
    logic [SEED_W:0]            dsum_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       wide_reg;
    logic                       wide_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [OUT_W-1:0]    out_sample_reg;
    logic signed [OUT_W-1:0]    out_sample_next;

    logic                       out_free;
    logic                       finish;
    logic [SEED_W-1:0]          mult_op;
    logic [SEED_W-1:0]          lcg_val;
    logic signed [SUM_W-1:0]    base;
    logic signed [SUM_W-1:0]    total;
    logic signed [Q_W-1:0]      quot;
    logic signed [Q_W-1:0]      lim_lo;
    logic signed [Q_W-1:0]      lim_hi;
    logic signed [Q_W-1:0]      quot_sat;

    // Output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || dout.ready;
    assign finish   = (state_reg == ST_FINISH) && out_free;
    assign pop      = !q_stat.empty && ((state_reg == ST_IDLE) || finish);

    // Shared LCG step: seed on the first step, first dither word on the second
    assign mult_op = (state_reg == ST_STEP2) ? d1_reg : seed_reg;
    assign lcg_val = mult_op * LCG_MUL + LCG_ADD;

    // Scale the sample onto the 2^-33 grid and add the dither pair
    always_comb
    begin
        if (wide_reg)
        begin
            base = {{2{sample_reg[SAMPLE_W-1]}}, sample_reg, 32'b0};
        end
        else
        begin
            base = {{10{sample_reg[SAMPLE_W-1]}}, sample_reg, 24'b0};
        end
        total = base + $signed({{(SUM_W - SEED_W - 1){1'b0}}, dsum_reg});
        quot  = total[SUM_W-1:Q_SHIFT];
    end

    // Clamp to the selected sample width
    always_comb
    begin
        lim_lo = wide_reg ? LIM24_LO : LIM16_LO;
        lim_hi = wide_reg ? LIM24_HI : LIM16_HI;
        if (quot < lim_lo)
        begin
            quot_sat = lim_lo;
        end
        else if (quot > lim_hi)
        begin
            quot_sat = lim_hi;
        end
        else
        begin
            quot_sat = quot;
        end
    end

    // Sequence one word: first step on pop, second step, then quantize into the output
    always_comb
    begin
        state_next      = state_reg;
        seed_next       = seed_reg;
        d1_next         = d1_reg;
        dsum_next       = dsum_reg;
        sample_next     = sample_reg;
        wide_next       = wide_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_STEP2;
                end
            end
            ST_STEP2:
            begin
                seed_next  = lcg_val;
                dsum_next  = {1'b0, d1_reg} + {1'b0, lcg_val};
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = quot_sat[OUT_W-1:0];
                    state_next      = pop ? ST_STEP2 : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the next word and its first dither word
        if (pop)
        begin
            d1_next     = lcg_val;
            sample_next = head_word.sample;
            wide_next   = head_word.wide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg         <= d1_next;
        dsum_reg       <= dsum_next;
        sample_reg     <= sample_next;
        wide_reg       <= wide_next;
        out_sample_reg <= out_sample_next;
    end

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_sample_reg;

endmodule

// ===== hw/rtl/tpdf_dither_quantizer.sv =====
// Top level of the TPDF dither quantizer: front, queue and back joined together.
// Depends on tpdq_pkg, tpdq_if, tpdq_front, tpdq_queue and tpdq_back.
//
// Usage:
//   din carries one signed Q8.24 sample word per handshake (valid and ready both
//   high at a rising edge). dout carries one quantized 24-bit signed word back
//   for every input word, in order. cfg_we with cfg_wdata sets the width mode
//   (0: 16-bit result, 1: 24-bit result); write it only while the block is idle.
//   Each word steps a 32-bit LCG twice, adds both dither words to the scaled
//   sample, floors by 2^33 and clamps to the selected width.
//   The single LCG multiplier serves both steps of each word, so the back works
//   on one word at a time and pops the next word as it delivers the last.
//   The front keeps accepting into a QUEUE_DEPTH-word queue while the back works;
//   when the receiver stalls, the result holds in the output register, the back
//   waits with its next result, and din.ready drops once the queue is full.
//   Reset clears the queue and output valid, sets the mode to 16-bit and loads
//   the LCG seed with its start value; no clearing pass is needed.
module tpdf_dither_quantizer
#(
    parameter int QUEUE_DEPTH = tpdq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    tpdq_in_if.sink     din,
    tpdq_out_if.source  dout,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import tpdq_pkg::*;

    qstat_t q_stat;
    qword_t push_word;
    qword_t head_word;
    logic   push;
    logic   pop;

    // Accept and tag words
    tpdq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_word (push_word)
    );

    // Decouple the front from the back
    tpdq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .q_stat    (q_stat)
    );

    // Dither, quantize and deliver
    tpdq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_word (head_word),
        .pop       (pop),
        .dout      (dout)
    );

endmodule

// ===== hw/rtl/tpdq_checker.sv =====
// Port-level checker for the TPDF dither quantizer and the bind that attaches it.
// Depends on tpdq_pkg and the top level tpdf_dither_quantizer.
module tpdq_checker
#(
    parameter int QUEUE_DEPTH = tpdq_pkg::QUEUE_DEPTH_DEF
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [tpdq_pkg::OUT_W-1:0] out_sample,
    input logic                              cfg_we,
    input logic                              cfg_wdata
);
    import tpdq_pkg::*;

    // Queue words, one in the back, one in the output register
    localparam int CAP   = QUEUE_DEPTH + 2;
    localparam int CNT_W = $clog2(CAP + 1) + 1;

    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic             mode_reg;
    logic             mode_next;
    logic             in_fire;
    logic             out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Track words accepted but not yet delivered, and the width mode
    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && !out_fire)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_fire && !in_fire)
        begin
            pend_next = pend_reg - 1'b1;
        end
        mode_next = cfg_we ? cfg_wdata : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            mode_reg <= MODE_16;
        end
        else
        begin
            pend_reg <= pend_next;
            mode_reg <= mode_next;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
        else $error("stalled result changed or dropped");

    // Never show a result with no word outstanding
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result without an accepted word");

    // Outstanding words stay within the block's storage
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_W'(CAP))
        else $error("more words outstanding than the block can hold");

    // 16-bit mode keeps results inside the 16-bit range
    a_range16: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode_reg == MODE_16) |->
            out_sample[OUT_W-1:15] == '0 || out_sample[OUT_W-1:15] == '1)
        else $error("16-bit result out of range");

endmodule

bind tpdf_dither_quantizer tpdq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tpdq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_sample (dout.sample_out),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
);

// ===== test/tpdq_dither_checker.sv =====
`timescale 1ns / 1ps
// Checker for the TPDF dither quantizer: watches both streams and the mode port,
// predicts every quantized word and compares it in order. Depends on tpdq_pkg and tpdq_if.
module tpdq_dither_checker
    import tpdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tpdq_in_if         din,
    tpdq_out_if        dout,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    output int         mismatches,
    output int         words_due,
    output int         words_checked
);

    logic [SEED_W-1:0] lcg_seed;
    logic              wide_mode;
    logic [OUT_W-1:0]  quant_due [$];

    // Step the noise source twice, add both dither words to the scaled sample,
    // floor by 2^33 and clamp to the selected width
    function automatic logic [OUT_W-1:0] dither_quantize(input logic signed [SAMPLE_W-1:0] smp);
        logic [SEED_W-1:0]       d1;
        logic [SEED_W-1:0]       d2;
        logic signed [SUM_W-1:0] smp_wide;
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] q;
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] hi;
        d1 = lcg_seed * LCG_MUL + LCG_ADD;
        d2 = d1 * LCG_MUL + LCG_ADD;
        lcg_seed = d2;
        smp_wide = smp;
        total = (wide_mode == MODE_24) ? (smp_wide <<< 32) : (smp_wide <<< 24);
        total = total + $signed({33'b0, d1}) + $signed({33'b0, d2});
        q = total >>> Q_SHIFT;
        lo = (wide_mode == MODE_24) ? LIM24_LO : LIM16_LO;
        hi = (wide_mode == MODE_24) ? LIM24_HI : LIM16_HI;
        if (q < lo)
        begin
            q = lo;
        end
        else if (q > hi)
        begin
            q = hi;
        end
        return q[OUT_W-1:0];
    endfunction

    // Track mode writes, predict accepted samples, compare returned words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_seed      = SEED_RESET;
            wide_mode     = MODE_16;
            quant_due.delete();
            mismatches    = 0;
            words_checked = 0;
            words_due     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                wide_mode = cfg_wdata;
            end
            if (din.valid && din.ready)
            begin
                quant_due.push_back(dither_quantize(din.sample_in));
            end
            if (dout.valid && dout.ready)
            begin
                if (quant_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, got sample_out=%0d",
                             $time, $signed(dout.sample_out));
                end
                else
                begin
                    words_checked++;
                    if (dout.sample_out !== quant_due[0])
                    begin
                        mismatches++;
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, $signed(quant_due[0]), $signed(dout.sample_out));
                    end
                    void'(quant_due.pop_front());
                end
            end
            words_due = quant_due.size();
        end
    end

endmodule

// ===== test/tpdf_dither_quantizer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the TPDF dither quantizer: clock, reset, sample stimulus with random
// gaps and stalls, mode changes, watchdog and verdict. Depends on tpdq_pkg, tpdq_if,
// tpdf_dither_quantizer and tpdq_dither_checker.
module tpdf_dither_quantizer_tb;
    import tpdq_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_WORDS   = 235;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    int mismatches;
    int words_due;
    int words_checked;
    int idle_cycles;
    int words_sent;
    int mode_writes;

    // Per-phase switches that remove the idling on one side
    logic source_steady;
    logic sink_steady;

    tpdq_in_if  din_if ();
    tpdq_out_if dout_if ();

    tpdf_dither_quantizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_if.sink),
        .dout      (dout_if.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tpdq_dither_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (din_if),
        .dout          (dout_if),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .words_due     (words_due),
        .words_checked (words_checked)
    );

    always #2 clk = ~clk;

    // Hand one sample word to the block after a random gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, 17);
        repeat (gap)
        begin
            @(negedge clk);
            din_if.valid <= 1'b0;
        end
        @(negedge clk);
        din_if.valid     <= 1'b1;
        din_if.sample_in <= smp;
        do
            @(posedge clk);
        while (!(din_if.valid && din_if.ready));
        words_sent++;
    endtask

    // Wait for every predicted word, then let the pipeline settle
    task automatic drain_words();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (words_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mode_writes++;
    endtask

    // Mostly in-range audio, some near zero, some around full scale, some raw words
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int kind;
        int val;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            val = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
        end
        else if (kind == 6)
        begin
            val = int'($urandom_range(0, 2047)) - 1024;
        end
        else if (kind == 7)
        begin
            val = int'($urandom_range(0, 4095)) - 2048;
            val = $urandom_range(0, 1) ? val + 32'h0100_0000 : val - 32'h0100_0000;
        end
        else
        begin
            val = $urandom;
        end
        return val;
    endfunction

    // Receiver: stall a random number of cycles before taking each word
    initial
    begin
        int stall;
        dout_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_steady ? 0 : $urandom_range(0, 17);
            repeat (stall)
            begin
                @(negedge clk);
                dout_if.ready <= 1'b0;
            end
            @(negedge clk);
            dout_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(dout_if.valid && dout_if.ready));
        end
    end

    // Count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with no word accepted", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] edge_samples [12];
        logic                mode;
        edge_samples = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h0100_0000, 32'hFF00_0000, 32'h00FF_FFFF,
            32'hFF00_0001, 32'h0000_0200, 32'h5555_5555, 32'hAAAA_AAAA
        };
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        din_if.valid     = 1'b0;
        din_if.sample_in = '0;
        source_steady    = 1'b0;
        sink_steady      = 1'b0;
        idle_cycles      = 0;
        words_sent       = 0;
        mode_writes      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes and full scale in the reset mode (16-bit), then in 24-bit mode
        foreach (edge_samples[i])
        begin
            send_sample(edge_samples[i]);
        end
        drain_words();
        write_mode(MODE_24);
        foreach (edge_samples[i])
        begin
            send_sample(edge_samples[i]);
        end

        // Random phases, each under its own mode and idling pattern
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_words();
            mode = (ph < 2) ? logic'(ph) : logic'($urandom_range(0, 1));
            write_mode(mode);
            source_steady = (ph % 4 == 2) || (ph == 7);
            sink_steady   = (ph % 4 == 3) || (ph == 7);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                send_sample(pick_sample());
            end
        end
        drain_words();

        $display("Sent %0d samples over %0d mode writes; %0d quantized words checked",
                 words_sent, mode_writes, words_checked);
        if (mismatches == 0 && words_due == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches, %0d words outstanding", mismatches, words_due);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
